[hw/rtl/assert_macros.svh]
// Assertion macros used by the mecanum wheel mixer top.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define MWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that must hold at every rising edge outside reset.
`define MWM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mwm_pkg.sv]
// Shared widths, register codes and types of the mecanum wheel mixer.
// No dependencies; used by every module of the block.
`default_nettype none

package mwm_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_WHEELS = 4;

    // Command path widths.
    localparam int VEL_W  = 16;
    localparam int MAG_W  = VEL_W + 1;
    localparam int SUM_W  = MAG_W;
    localparam int LIM_W  = 16;
    localparam int PROD_W = MAG_W + LIM_W;
    localparam int QUO_W  = LIM_W;
    localparam int VL_W   = QUO_W + 1;

    // Wheel path widths.
    localparam int COEF_W = 16;
    localparam int MUL_W  = VL_W + COEF_W;
    localparam int ACC_W  = MUL_W + 2;
    localparam int SPD_W  = 18;

    // One restoring step per quotient bit.
    localparam int DIV_STAGES = QUO_W;

    // Stream and register port widths.
    localparam int IN_W   = NUM_AXES * VEL_W;
    localparam int OUT_W  = NUM_WHEELS * SPD_W;
    localparam int REG_W  = 64;
    localparam int ADDR_W = 5;

    localparam logic [LIM_W-1:0] SAFETY_RESET = 16'd16384;
    localparam logic signed [SPD_W-1:0] SPEED_MAX = 18'sd131071;
    localparam logic signed [SPD_W-1:0] SPEED_MIN = -18'sd131072;

    typedef enum logic [1:0] {
        REG_SAFETY    = 2'd0,
        REG_COEFF_X   = 2'd1,
        REG_COEFF_Y   = 2'd2,
        REG_COEFF_ROT = 2'd3
    } reg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [LIM_W-1:0]                 safety_limit;
        logic [NUM_AXES-1:0][REG_W-1:0]   coeff_row;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/mwm_cfg_regs.sv]
// APB register file: safety limit and the three coefficient rows.
// Depends on mwm_pkg.
`default_nettype none

module mwm_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mwm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mwm_pkg::REG_W-1:0]     pwdata,
    output logic      [mwm_pkg::REG_W-1:0]     prdata,
    output logic                               pready,
    output mwm_pkg::cfg_t                      cfg
);

    logic [mwm_pkg::LIM_W-1:0]                         safety_reg;
    logic [mwm_pkg::NUM_AXES-1:0][mwm_pkg::REG_W-1:0]  coeff_reg;
    mwm_pkg::reg_idx_t                                 idx;
    logic                                              wr;

    assign pready = 1'b1;
    assign idx    = mwm_pkg::reg_idx_t'(paddr[mwm_pkg::ADDR_W-1:3]);
    assign wr     = psel && penable && pwrite;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safety_reg <= mwm_pkg::SAFETY_RESET;
            coeff_reg  <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                mwm_pkg::REG_SAFETY:    safety_reg   <= pwdata[mwm_pkg::LIM_W-1:0];
                mwm_pkg::REG_COEFF_X:   coeff_reg[0] <= pwdata;
                mwm_pkg::REG_COEFF_Y:   coeff_reg[1] <= pwdata;
                mwm_pkg::REG_COEFF_ROT: coeff_reg[2] <= pwdata;
                default:                safety_reg   <= safety_reg;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            mwm_pkg::REG_SAFETY:
                prdata = {{(mwm_pkg::REG_W - mwm_pkg::LIM_W){1'b0}}, safety_reg};
            mwm_pkg::REG_COEFF_X:   prdata = coeff_reg[0];
            mwm_pkg::REG_COEFF_Y:   prdata = coeff_reg[1];
            mwm_pkg::REG_COEFF_ROT: prdata = coeff_reg[2];
            default:                prdata = '0;
        endcase
    end

    assign cfg.safety_limit = safety_reg;
    assign cfg.coeff_row    = coeff_reg;

endmodule

`default_nettype wire

[hw/rtl/mwm_div_lane.sv]
// One axis lane of the limiter: pipelined restoring divider, one quotient bit per stage.
// Depends on mwm_pkg. The quotient is exact only when num / 2^QUO_W < den.
`default_nettype none

module mwm_div_lane (
    input  wire logic                              clk,
    input  wire logic [mwm_pkg::DIV_STAGES-1:0]    en,
    input  wire logic [mwm_pkg::PROD_W-1:0]        num,
    input  wire logic [mwm_pkg::SUM_W-1:0]         den,
    output logic      [mwm_pkg::QUO_W-1:0]         quo
);

    localparam int NS = mwm_pkg::DIV_STAGES;
    localparam int RW = mwm_pkg::SUM_W;
    localparam int QW = mwm_pkg::QUO_W;

    logic [RW-1:0] rem_reg  [NS];
    logic [QW-1:0] low_reg  [NS];
    logic [QW-1:0] quo_reg  [NS];
    logic [RW-1:0] den_reg  [NS];

    logic [RW-1:0] rem_next [NS];
    logic [QW-1:0] low_next [NS];
    logic [QW-1:0] quo_next [NS];
    logic [RW-1:0] den_next [NS];

    logic [RW-1:0] rem_src  [NS];
    logic [QW-1:0] low_src  [NS];
    logic [QW-1:0] quo_src  [NS];
    logic [RW:0]   trial    [NS];
    logic [RW:0]   diff     [NS];

    // Each stage shifts in one numerator bit and tries a subtract.
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                rem_src[k]  = num[mwm_pkg::PROD_W-1:QW];
                low_src[k]  = num[QW-1:0];
                quo_src[k]  = '0;
                den_next[k] = den;
            end
            else
            begin
                rem_src[k]  = rem_reg[k-1];
                low_src[k]  = low_reg[k-1];
                quo_src[k]  = quo_reg[k-1];
                den_next[k] = den_reg[k-1];
            end
            trial[k] = {rem_src[k], low_src[k][QW-1]};
            diff[k]  = trial[k] - {1'b0, den_next[k]};
            if (trial[k] >= {1'b0, den_next[k]})
            begin
                rem_next[k] = diff[k][RW-1:0];
                quo_next[k] = {quo_src[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][RW-1:0];
                quo_next[k] = {quo_src[k][QW-2:0], 1'b0};
            end
            low_next[k] = {low_src[k][QW-2:0], 1'b0};
        end
    end

    // Stage registers, each held while its stage is stalled.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule

`default_nettype wire

[hw/rtl/mwm_wheel_lane.sv]
// One wheel lane: three products, then sum, round half up and saturate to Q3.14.
// Depends on mwm_pkg.
`default_nettype none

module mwm_wheel_lane #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                              clk,
    input  wire logic [1:0]                                        en,
    input  wire logic [mwm_pkg::NUM_AXES-1:0][mwm_pkg::VL_W-1:0]   vel,
    input  wire logic [mwm_pkg::NUM_AXES-1:0][mwm_pkg::COEF_W-1:0] coef,
    output logic      [mwm_pkg::SPD_W-1:0]                         speed
);

    localparam int NA = mwm_pkg::NUM_AXES;
    localparam int MW = mwm_pkg::MUL_W;
    localparam int AW = mwm_pkg::ACC_W;
    localparam logic signed [AW-1:0] RND    = AW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [AW-1:0] SAT_HI = AW'(mwm_pkg::SPEED_MAX);
    localparam logic signed [AW-1:0] SAT_LO = AW'(mwm_pkg::SPEED_MIN);

    logic signed [MW-1:0]             prod_reg  [NA];
    logic signed [MW-1:0]             prod_next [NA];
    logic signed [AW-1:0]             acc;
    logic signed [AW-1:0]             shifted;
    logic        [mwm_pkg::SPD_W-1:0] speed_reg;
    logic        [mwm_pkg::SPD_W-1:0] speed_next;

    // Product stage: one signed multiply per axis.
    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            prod_next[j] = MW'($signed(vel[j])) * MW'($signed(coef[j]));
        end
    end

    // Sum stage: accumulate, round half up, floor shift, clamp.
    always_comb
    begin
        acc     = AW'(prod_reg[0]) + AW'(prod_reg[1]) + AW'(prod_reg[2]) + RND;
        shifted = acc >>> FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            speed_next = mwm_pkg::SPEED_MAX;
        end
        else if (shifted < SAT_LO)
        begin
            speed_next = mwm_pkg::SPEED_MIN;
        end
        else
        begin
            speed_next = shifted[mwm_pkg::SPD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < NA; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (en[1])
        begin
            speed_reg <= speed_next;
        end
    end

    assign speed = speed_reg;

endmodule

`default_nettype wire

[hw/rtl/mecanum_wheel_mixer_top.sv]
// Mecanum wheel mixer top: L1 limiter with three divider lanes, four wheel lanes.
// Stages in order: input, sum/product, divider, select, wheel product, wheel sum, output.
// Throughput: one word per cycle; a stalled output only fills bubbles behind it.
// The 16-stage divider (one quotient bit per stage) sets most of the latency.
// Reset (rst_n, asynchronous, active low) empties the pipeline, sets the limit to
// 1.0 (16384) and clears all coefficients.
`default_nettype none
`include "assert_macros.svh"

module mecanum_wheel_mixer_top #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // vel_x [15:0], vel_y [31:16], vel_rot [47:32]
    input  wire logic [mwm_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // wheel_speed_0 [17:0], wheel_speed_1 [35:18], wheel_speed_2 [53:36],
    // wheel_speed_3 [71:54]
    output logic      [mwm_pkg::OUT_W-1:0]     m_axis_tdata,
    // was_limited [0]
    output logic      [0:0]                    m_axis_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mwm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mwm_pkg::REG_W-1:0]     pwdata,
    output logic      [mwm_pkg::REG_W-1:0]     prdata,
    output logic                               pready
);

    localparam int NA      = mwm_pkg::NUM_AXES;
    localparam int NWH     = mwm_pkg::NUM_WHEELS;
    localparam int ND      = mwm_pkg::DIV_STAGES;
    localparam int VW      = mwm_pkg::VEL_W;
    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_SEL  = ST_DIV0 + ND;
    localparam int ST_WMUL = ST_SEL + 1;
    localparam int ST_WSUM = ST_WMUL + 1;
    localparam int NST     = ST_WSUM + 1;

    mwm_pkg::cfg_t cfg;

    // Pipeline control.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [NST:0]   rdy;

    // Input stage.
    logic [NA-1:0][VW-1:0]            vel0_reg;
    logic [NA-1:0][mwm_pkg::MAG_W-1:0] mag0_reg;
    logic [NA-1:0][mwm_pkg::MAG_W-1:0] mag0_next;

    // Sum and product stage.
    logic [NA-1:0][VW-1:0]              vel1_reg;
    logic [NA-1:0][mwm_pkg::PROD_W-1:0] prod1_reg;
    logic [NA-1:0][mwm_pkg::PROD_W-1:0] prod1_next;
    logic [mwm_pkg::SUM_W-1:0]          sum1_reg;
    logic [mwm_pkg::SUM_W-1:0]          sum1_next;
    logic                               lim1_reg;

    // Side pipeline along the divider.
    logic [NA-1:0][VW-1:0] vel_dv_reg [ND];
    logic                  lim_dv_reg [ND];
    logic [NA-1:0][mwm_pkg::QUO_W-1:0] quo;

    // Select stage and wheel path.
    logic [NA-1:0][mwm_pkg::VL_W-1:0]  vl_reg;
    logic [NA-1:0][mwm_pkg::VL_W-1:0]  vl_next;
    logic                              lim_sel_reg;
    logic                              lim_wm_reg;
    logic                              lim_ws_reg;
    logic [NWH-1:0][mwm_pkg::SPD_W-1:0] speed;
    logic [mwm_pkg::OUT_W-1:0]         tdata_reg;
    logic                              tuser_reg;
    logic [mwm_pkg::QUO_W+1:0]         quo_sum;

    mwm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Ready ripples back from the output register; bubbles are filled.
    always_comb
    begin
        rdy[NST] = !out_valid_reg || m_axis_tready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[ST_IN] = rdy[ST_IN] ? s_axis_tvalid : valid_reg[ST_IN];
        for (int k = 1; k < NST; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
        out_valid_next = rdy[NST] ? valid_reg[NST-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = rdy[ST_IN];

    // Absolute values of the incoming word.
    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            if (s_axis_tdata[j*VW + VW - 1])
            begin
                mag0_next[j] = mwm_pkg::MAG_W'(0)
                             - {s_axis_tdata[j*VW + VW - 1], s_axis_tdata[j*VW +: VW]};
            end
            else
            begin
                mag0_next[j] = {1'b0, s_axis_tdata[j*VW +: VW]};
            end
        end
    end

    // L1 sum and the scaled numerators mag * limit.
    always_comb
    begin
        sum1_next = mag0_reg[0] + mag0_reg[1] + mag0_reg[2];
        for (int j = 0; j < NA; j++)
        begin
            prod1_next[j] = mwm_pkg::PROD_W'(mag0_reg[j])
                          * mwm_pkg::PROD_W'(cfg.safety_limit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_IN])
        begin
            vel0_reg <= s_axis_tdata;
            mag0_reg <= mag0_next;
        end
        if (rdy[ST_MUL])
        begin
            vel1_reg  <= vel0_reg;
            prod1_reg <= prod1_next;
            sum1_reg  <= sum1_next;
            lim1_reg  <= sum1_next > {1'b0, cfg.safety_limit};
        end
    end

    // Divider lanes, one per axis.
    for (genvar j = 0; j < NA; j++)
    begin : g_div
        mwm_div_lane u_div (
            .clk (clk),
            .en  (rdy[ST_DIV0 +: ND]),
            .num (prod1_reg[j]),
            .den (sum1_reg),
            .quo (quo[j])
        );
    end

    // Command and limit flag travel beside the divider.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ND; k++)
        begin
            if (rdy[ST_DIV0 + k])
            begin
                if (k == 0)
                begin
                    vel_dv_reg[k] <= vel1_reg;
                    lim_dv_reg[k] <= lim1_reg;
                end
                else
                begin
                    vel_dv_reg[k] <= vel_dv_reg[k-1];
                    lim_dv_reg[k] <= lim_dv_reg[k-1];
                end
            end
        end
    end

    // Merge: in a limited word each component takes the signed quotient; others pass through.
    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            if (!lim_dv_reg[ND-1])
            begin
                vl_next[j] = {vel_dv_reg[ND-1][j][VW-1], vel_dv_reg[ND-1][j]};
            end
            else if (vel_dv_reg[ND-1][j][VW-1])
            begin
                vl_next[j] = mwm_pkg::VL_W'(0) - {1'b0, quo[j]};
            end
            else
            begin
                vl_next[j] = {1'b0, quo[j]};
            end
        end
        quo_sum = (mwm_pkg::QUO_W + 2)'(quo[0]) + (mwm_pkg::QUO_W + 2)'(quo[1])
                + (mwm_pkg::QUO_W + 2)'(quo[2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SEL])
        begin
            vl_reg      <= vl_next;
            lim_sel_reg <= lim_dv_reg[ND-1];
        end
        if (rdy[ST_WMUL])
        begin
            lim_wm_reg <= lim_sel_reg;
        end
        if (rdy[ST_WSUM])
        begin
            lim_ws_reg <= lim_wm_reg;
        end
    end

    // Wheel lanes, one per wheel.
    for (genvar i = 0; i < NWH; i++)
    begin : g_wheel
        logic [NA-1:0][mwm_pkg::COEF_W-1:0] coef;

        always_comb
        begin
            for (int j = 0; j < NA; j++)
            begin
                coef[j] = cfg.coeff_row[j][i*mwm_pkg::COEF_W +: mwm_pkg::COEF_W];
            end
        end

        mwm_wheel_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_wheel (
            .clk   (clk),
            .en    ({rdy[ST_WSUM], rdy[ST_WMUL]}),
            .vel   (vl_reg),
            .coef  (coef),
            .speed (speed[i])
        );
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (rdy[NST])
        begin
            tdata_reg <= speed;
            tuser_reg <= lim_ws_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = tdata_reg;
    assign m_axis_tuser[0] = tuser_reg;

    // With the output register empty nothing can hold back the input.
    `MWM_ASSERT_IMPL(a_ready_when_drained, !out_valid_reg, s_axis_tready,
        "input stalled although the output register is empty")

    // A limited word never reaches the divider with a zero L1 sum.
    `MWM_ASSERT_IMPL(a_no_zero_divisor, valid_reg[ST_MUL] && lim1_reg, sum1_reg != '0,
        "limited word with zero divisor")

    // Scaled magnitudes together never exceed the safety limit.
    `MWM_ASSERT_IMPL(a_scaled_within_limit,
        valid_reg[ST_SEL-1] && lim_dv_reg[ND-1],
        quo_sum <= (mwm_pkg::QUO_W + 2)'(cfg.safety_limit),
        "scaled command exceeds the safety limit")

endmodule

`default_nettype wire

[tb/tb_mecanum_wheel_mixer_top.sv]
// Self-checking testbench for the mecanum wheel mixer top: drives commands on the
// input stream, loads the limit and coefficient registers over APB, and checks every
// output word against a scoreboard. Depends on mwm_pkg and the mixer RTL.
`default_nettype none

module tb_mecanum_wheel_mixer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_AXES    = mwm_pkg::NUM_AXES;
    localparam int NUM_WHEELS  = mwm_pkg::NUM_WHEELS;
    localparam int VEL_W       = mwm_pkg::VEL_W;
    localparam int SPD_W       = mwm_pkg::SPD_W;
    localparam int LIM_W       = mwm_pkg::LIM_W;
    localparam int REG_W       = mwm_pkg::REG_W;
    localparam int COEF_W      = mwm_pkg::COEF_W;
    localparam int IN_W        = mwm_pkg::IN_W;
    localparam int OUT_W       = mwm_pkg::OUT_W;
    localparam int ADDR_W      = mwm_pkg::ADDR_W;

    localparam int FRAC        = 14;
    localparam int HOLD_CYCLES = 200;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 325;

    // One command word: vel_x in the low bits, then vel_y, then vel_rot.
    typedef struct packed {
        logic [NUM_AXES-1:0][VEL_W-1:0] vel;
    } command_t;

    // One expected output word with its limit flag.
    typedef struct packed {
        logic [NUM_WHEELS-1:0][SPD_W-1:0] wheel_speed;
        logic                             was_limited;
    } wheel_result_t;

    // Scoreboard: holds a copy of the registers and the wheel speeds still owed.
    class mixer_scoreboard;
        logic [LIM_W-1:0] safety_limit;
        logic [REG_W-1:0] coeff_row [NUM_AXES];
        wheel_result_t    speeds_owed [$];
        int               mismatches;

        function new();
            safety_limit = mwm_pkg::SAFETY_RESET;
            foreach (coeff_row[j]) coeff_row[j] = '0;
            mismatches = 0;
        endfunction

        function void load_register(mwm_pkg::reg_idx_t idx, logic [REG_W-1:0] value);
            case (idx)
                mwm_pkg::REG_SAFETY:    safety_limit = value[LIM_W-1:0];
                mwm_pkg::REG_COEFF_X:   coeff_row[0] = value;
                mwm_pkg::REG_COEFF_Y:   coeff_row[1] = value;
                mwm_pkg::REG_COEFF_ROT: coeff_row[2] = value;
                default:       ;
            endcase
        endfunction

        // Limit the command by its L1 magnitude, then mix it into four wheel speeds.
        function wheel_result_t mix(command_t cmd);
            longint        v [NUM_AXES];
            longint        mag;
            longint        total;
            longint        lim;
            longint        acc;
            longint        spd;
            wheel_result_t r;
            total = 0;
            lim   = safety_limit;
            for (int j = 0; j < NUM_AXES; j++)
            begin
                v[j]  = longint'($signed(cmd.vel[j]));
                total += (v[j] < 0) ? -v[j] : v[j];
            end
            r.was_limited = (total > lim);
            if (r.was_limited)
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    mag  = (v[j] < 0) ? -v[j] : v[j];
                    mag  = (mag * lim) / total;
                    v[j] = (v[j] < 0) ? -mag : mag;
                end
            end
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                acc = 0;
                for (int j = 0; j < NUM_AXES; j++)
                    acc += v[j] * longint'($signed(coeff_row[j][COEF_W*w +: COEF_W]));
                // Round half up, then drop the fraction with a floor shift.
                spd = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
                if (spd > 131071)
                    spd = 131071;
                if (spd < -131072)
                    spd = -131072;
                r.wheel_speed[w] = spd[SPD_W-1:0];
            end
            return r;
        endfunction

        function void note_command(command_t cmd);
            speeds_owed.push_back(mix(cmd));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic limited);
            wheel_result_t exp;
            if (speeds_owed.size() == 0)
            begin
                flag($sformatf("output word %h with no command outstanding", data));
                return;
            end
            exp = speeds_owed.pop_front();
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                if (data[SPD_W*w +: SPD_W] !== exp.wheel_speed[w])
                    flag($sformatf("wheel %0d speed: expected %0d, actual %0d", w,
                                   $signed(exp.wheel_speed[w]),
                                   $signed(data[SPD_W*w +: SPD_W])));
            end
            if (limited !== exp.was_limited)
                flag($sformatf("limit flag: expected %b, actual %b",
                               exp.was_limited, limited));
        endfunction

        function int pending();
            return speeds_owed.size();
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    // vel_x [15:0], vel_y [31:16], vel_rot [47:32]
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // wheel_speed_0 [17:0], wheel_speed_1 [35:18], wheel_speed_2 [53:36],
    // wheel_speed_3 [71:54]
    wire  [OUT_W-1:0]    m_axis_tdata;
    // was_limited [0]
    wire  [0:0]          m_axis_tuser;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [REG_W-1:0]    pwdata        = '0;
    wire  [REG_W-1:0]    prdata;
    wire                 pready;

    // Both sides run without gaps while steady is set; hold_request starts one long stall.
    logic                steady        = 1'b0;
    logic                hold_request  = 1'b0;

    mixer_scoreboard sb;

    mecanum_wheel_mixer_top #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    // Watch both streams at the clock edge where words are accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(command_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Output side: random stalls, no stalls while steady, and one long hold-off.
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 22);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_command(input command_t cmd);
        while (!steady && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_register(input mwm_pkg::reg_idx_t idx,
                                  input logic [REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.load_register(idx, value);
        // Leave the bus idle between transfers.
        @(posedge clk);
    endtask

    // Registers change only once every owed word has come out.
    task automatic configure(input logic [LIM_W-1:0] limit, input logic [REG_W-1:0] row_x,
                             input logic [REG_W-1:0] row_y, input logic [REG_W-1:0] row_rot);
        s_axis_tvalid <= 1'b0;
        // Let the monitor note the last accepted command first.
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_register(mwm_pkg::REG_SAFETY, {48'd0, limit});
        write_register(mwm_pkg::REG_COEFF_X, row_x);
        write_register(mwm_pkg::REG_COEFF_Y, row_y);
        write_register(mwm_pkg::REG_COEFF_ROT, row_rot);
    endtask

    // Hand-picked commands: zero, at and just past the limit, the field extremes.
    function automatic command_t corner_command(int k);
        command_t c;
        c = '0;
        case (k)
            1: c.vel[0] = 16'd16384;
            2: c.vel[0] = 16'd16385;
            3: c.vel    = {16'h8000, 16'h8000, 16'h8000};
            4: c.vel    = {16'h7FFF, 16'h7FFF, 16'h7FFF};
            5: c.vel    = {16'h0000, 16'h7FFF, 16'h8000};
            6: c.vel    = {16'h0001, 16'hFFFF, 16'h0001};
            7: c.vel[2] = 16'hC000;
            8: c.vel    = {16'h2000, 16'hE000, 16'h2000};
            9: c.vel    = {16'h0000, 16'h0001, 16'd16383};
            default: c = '0;
        endcase
        return c;
    endfunction

    // Full-range words half the time, plus small commands near the limit, extremes and
    // commands whose L1 sum lands exactly on the limit.
    function automatic command_t random_command();
        command_t c;
        int       lim;
        int       a;
        int       b;
        int       r;
        case ($urandom_range(9)) inside
            [5:7]:
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    r        = int'($urandom_range(24000)) - 12000;
                    c.vel[j] = 16'(r);
                end
            end
            8:
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    case ($urandom_range(4))
                        0: c.vel[j] = 16'h8000;
                        1: c.vel[j] = 16'h7FFF;
                        2: c.vel[j] = 16'h0000;
                        3: c.vel[j] = 16'h0001;
                        default: c.vel[j] = 16'hFFFF;
                    endcase
                end
            end
            9:
            begin
                lim = int'(sb.safety_limit);
                a   = $urandom_range(0, (lim < 32767) ? lim : 32767);
                b   = lim - a;
                if (b > 32767)
                    b = 32767;
                c.vel[0] = $urandom_range(1) ? 16'(-a) : 16'(a);
                c.vel[1] = $urandom_range(1) ? 16'(-b) : 16'(b);
                c.vel[2] = $urandom_range(1) ? 16'(-(lim - a - b)) : 16'(lim - a - b);
            end
            default: c.vel = IN_W'({$urandom, $urandom});
        endcase
        return c;
    endfunction

    initial
    begin
        logic [LIM_W-1:0] limit;
        sb = new();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: limit 1.0, all coefficients zero.
        for (int k = 0; k < 3; k++)
            send_command(corner_command(k));

        // Standard mecanum matrix at a limit of 1.0.
        configure(16'd16384, 64'h4000_4000_4000_4000, 64'hC000_4000_4000_C000,
                  64'h4000_C000_4000_C000);
        for (int k = 0; k < 10; k++)
            send_command(corner_command(k));

        // Zero limit forces every nonzero command to zero.
        configure(16'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                  64'h8000_8000_8000_8000);
        send_command(corner_command(0));
        send_command(corner_command(2));
        send_command(corner_command(3));
        send_command(corner_command(4));

        // Widest limit with full-scale coefficients drives the outputs close to the ends of their range.
        configure(16'hFFFF, 64'h7FFF_8000_7FFF_8000, 64'h7FFF_7FFF_8000_8000,
                  64'h8000_7FFF_7FFF_8000);
        for (int k = 3; k < 8; k++)
            send_command(corner_command(k));

        // Random phases, each with its own register setting.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(3))
                0: limit = 16'($urandom);
                1: limit = 16'd16384;
                2: limit = 16'hFFFF;
                default: limit = 16'($urandom_range(255));
            endcase
            configure(limit, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
            if (p == 1)
                hold_request <= 1'b1;
            steady <= (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_command(random_command());
        end
        steady        <= 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then give any stray word time to show up.
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/mwm_pkg.sv
hw/rtl/mwm_cfg_regs.sv
hw/rtl/mwm_div_lane.sv
hw/rtl/mwm_wheel_lane.sv
hw/rtl/mecanum_wheel_mixer_top.sv
tb/tb_mecanum_wheel_mixer_top.sv
